>>> hdl/tsrs_pkg.sv
// Shared types, codes and constants for the temperature read sequencer.
`timescale 1ns / 1ps

package tsrs_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned WHOLE_W = 8;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned TICK_W  = 7;
  localparam int unsigned RES_W   = 2;
  localparam int unsigned DSEL_W  = 3;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 3;

  localparam logic [ADDR_W-1:0] BASE_ADDRESS = 7'h48;
  localparam logic [CMD_W-1:0]  CMD_CONVERT  = 8'h51;
  localparam logic [CMD_W-1:0]  CMD_READ     = 8'hAA;
  localparam logic [TICK_W-1:0] TICK_BASE    = 7'd10;

  localparam logic [RES_W-1:0]  RES_RESET  = 2'd3;
  localparam logic [DSEL_W-1:0] DSEL_RESET = 3'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_SEL = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_TICK  = 3'd1,
    OP_DONE  = 3'd2,
    OP_ERROR = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE    = 2'd0,
    REQ_CONVERT = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_ACK  = 3'd1,
    PH_CONVERT   = 3'd2,
    PH_WAIT_READ = 3'd3,
    PH_COMPLETE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  fraction_digits;
    logic [WHOLE_W-1:0] whole_degrees;
    logic               is_negative;
    logic               measurement_complete;
    logic [CMD_W-1:0]   command_byte;
    logic [ADDR_W-1:0]  bus_address;
  } result_data_t;

  // Weight of one fraction step: 10^(r+1) / 2^(r+1)
  function automatic logic [9:0] frac_weight(input logic [RES_W-1:0] r);
    logic [9:0] w;
    unique case (r)
      2'd0:    w = 10'd5;
      2'd1:    w = 10'd25;
      2'd2:    w = 10'd125;
      default: w = 10'd625;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/temp_sensor_read_sequencer_unit.sv
// Top level of the temperature read sequencer.
`timescale 1ns / 1ps

// Temperature read sequencer.
// Input stream: in_tuser carries the operation (start, 10 ms tick, bus done,
// bus error, query), in_tdata the two received bytes that go with bus done.
// Every accepted input transaction yields exactly one result transaction:
// out_tuser carries the bus request (none, start-convert, read), out_tdata
// the bus address, command byte, completion flag and, on a query while a
// reading is stored, its sign, whole degrees and scaled decimal fraction.
// Configuration: cfg_index 0 selects the resolution code, 1 the low address
// bits; cfg_ready is always high. Write it only while no transaction is open.
// Each result is registered, into the skid register if the output waits.
// Throughput: one transaction per cycle while in_tready is high; the whole
// step is a single pass of logic from the input port into the result
// register, and the next state is written in the same edge.
// Stall: a two-entry result buffer (output register plus skid register) lets
// the block take one more input while a result waits; in_tready drops only
// when both entries are full, and is itself a register output.
// Reset (rst_n low, synchronous): phase idle, tick count and stored reading
// cleared, resolution 12 bit, device select 0, both result entries empty.
module temp_sensor_read_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tsrs_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] read_data
  input  logic [tsrs_pkg::IN_TUSER_W-1:0]      in_tuser,   // [2:0] operation
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [6:0] bus_address, [14:7] command_byte, [15] measurement_complete,
  // [16] is_negative, [24:17] whole_degrees, [38:25] fraction_digits, [39] zero
  output logic [tsrs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [tsrs_pkg::OUT_TUSER_W-1:0]     out_tuser,  // [1:0] bus_request
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tsrs_pkg::phase_t                   phase_r, phase_nxt;
  logic [tsrs_pkg::TICK_W-1:0]        tick_r, tick_nxt;
  logic [tsrs_pkg::DATA_W-1:0]        reading_r, reading_nxt;
  logic [tsrs_pkg::RES_W-1:0]         res_r;
  logic [tsrs_pkg::DSEL_W-1:0]        dsel_r;

  tsrs_pkg::result_data_t             res_data;
  tsrs_pkg::req_t                     res_req;

  tsrs_pkg::result_data_t             out_data_r, skid_data_r;
  tsrs_pkg::req_t                     out_req_r, skid_req_r;
  logic                               out_valid_r, skid_valid_r;

  logic                               in_fire, out_fire;
  tsrs_pkg::op_t                      op;
  logic [tsrs_pkg::ADDR_W-1:0]        addr;
  logic [tsrs_pkg::TICK_W-1:0]        tick_inc;
  logic [tsrs_pkg::TICK_W-1:0]        tick_limit;
  logic                               neg;
  logic [tsrs_pkg::DATA_W-1:0]        mag;
  logic [7:0]                         frac_shift;
  logic [3:0]                         frac_steps;
  logic [3:0]                         frac_mask;
  logic [tsrs_pkg::FRAC_W-1:0]        frac_val;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  assign op   = tsrs_pkg::op_t'(in_tuser);
  assign addr = tsrs_pkg::BASE_ADDRESS | {4'd0, dsel_r};

  assign tick_inc   = tick_r + 7'd1;
  assign tick_limit = tsrs_pkg::TICK_BASE << res_r;

  // Reading decode: magnitude over the full 16 bits, fraction from the top
  // res+1 bits of the low byte, each step weighted by 10^(r+1)/2^(r+1).
  assign neg        = reading_r[15];
  assign mag        = neg ? (16'd0 - reading_r) : reading_r;
  assign frac_shift = mag[7:0] >> (3'd7 - {1'b0, res_r});
  assign frac_mask  = 4'hF >> (2'd3 - res_r);
  assign frac_steps = frac_shift[3:0] & frac_mask;
  assign frac_val   = tsrs_pkg::FRAC_W'({10'd0, frac_steps} * tsrs_pkg::frac_weight(res_r));

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    reading_nxt = reading_r;
    res_req     = tsrs_pkg::REQ_NONE;
    res_data    = '0;
    unique case (op)
      tsrs_pkg::OP_START: begin
        res_req   = tsrs_pkg::REQ_CONVERT;
        phase_nxt = tsrs_pkg::PH_WAIT_ACK;
        tick_nxt  = '0;
      end
      tsrs_pkg::OP_TICK: begin
        if (phase_r == tsrs_pkg::PH_CONVERT) begin
          tick_nxt = tick_inc;
          if (tick_inc >= tick_limit) begin
            res_req   = tsrs_pkg::REQ_READ;
            phase_nxt = tsrs_pkg::PH_WAIT_READ;
            tick_nxt  = '0;
          end
        end
      end
      tsrs_pkg::OP_DONE: begin
        if (phase_r == tsrs_pkg::PH_WAIT_ACK) begin
          phase_nxt = tsrs_pkg::PH_CONVERT;
          tick_nxt  = '0;
        end else if (phase_r == tsrs_pkg::PH_WAIT_READ) begin
          reading_nxt = in_tdata;
          phase_nxt   = tsrs_pkg::PH_COMPLETE;
        end
      end
      tsrs_pkg::OP_ERROR: begin
        if (phase_r == tsrs_pkg::PH_WAIT_ACK || phase_r == tsrs_pkg::PH_WAIT_READ) begin
          res_req   = tsrs_pkg::REQ_CONVERT;
          phase_nxt = tsrs_pkg::PH_WAIT_ACK;
          tick_nxt  = '0;
        end
      end
      tsrs_pkg::OP_QUERY: begin
        if (phase_r == tsrs_pkg::PH_COMPLETE) begin
          res_data.is_negative     = neg;
          res_data.whole_degrees   = mag[15:8];
          res_data.fraction_digits = frac_val;
        end
      end
      default: begin
      end
    endcase
    unique case (res_req)
      tsrs_pkg::REQ_CONVERT: begin
        res_data.bus_address  = addr;
        res_data.command_byte = tsrs_pkg::CMD_CONVERT;
      end
      tsrs_pkg::REQ_READ: begin
        res_data.bus_address  = addr;
        res_data.command_byte = tsrs_pkg::CMD_READ;
      end
      default: begin
      end
    endcase
    res_data.measurement_complete = (phase_nxt == tsrs_pkg::PH_COMPLETE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tsrs_pkg::PH_IDLE;
      tick_r    <= '0;
      reading_r <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      reading_r <= reading_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= tsrs_pkg::RES_RESET;
      dsel_r <= tsrs_pkg::DSEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsrs_pkg::REG_RESOLUTION: res_r  <= cfg_data[tsrs_pkg::RES_W-1:0];
        default:                  dsel_r <= cfg_data;
      endcase
    end
  end

  // Result buffer: output register backed by one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
        out_req_r  <= skid_req_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res_data;
        out_req_r  <= res_req;
      end else begin
        skid_data_r <= res_data;
        skid_req_r  <= res_req;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_req_r;

endmodule

>>> hdl/tsrs_checker.sv
// Port-level checker for the temperature read sequencer, bound to the top level.
`timescale 1ns / 1ps

module tsrs_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tsrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [tsrs_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // Result register empties on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // No request means no address and no command.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tsrs_pkg::REQ_NONE |-> out_tdata[14:0] == 15'd0)
    else $error("address or command without a request");

  a_cmd_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tsrs_pkg::REQ_CONVERT
      |-> out_tdata[14:7] == tsrs_pkg::CMD_CONVERT)
    else $error("start-convert request with wrong command");

  // A sign is only reported for a completed reading.
  a_sign_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15])
    else $error("sign reported without a completed reading");

endmodule

bind temp_sensor_read_sequencer_unit tsrs_port_checker u_tsrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/tsrs_checker.sv
// Checker that predicts and compares every result of the temperature read sequencer.
`timescale 1ns / 1ps

module tsrs_checker
  import tsrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] read_data
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [2:0] operation
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [6:0] bus_address, [14:7] command_byte, [15] measurement_complete,
  // [16] is_negative, [24:17] whole_degrees, [38:25] fraction_digits, [39] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] bus_request
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic [REQ_W-1:0] req;
    result_data_t     data;
  } reading_result_t;

  logic [RES_W-1:0]  res_code;
  logic [DSEL_W-1:0] dev_sel;
  phase_t            seq_phase;
  logic [TICK_W-1:0] conv_ticks;
  logic [DATA_W-1:0] last_reading;
  reading_result_t   expected_q[$];
  reading_result_t   want;
  result_data_t      seen;

  function automatic reading_result_t issue_transfer(input logic [REQ_W-1:0] req,
                                                     input logic [CMD_W-1:0] cmd);
    reading_result_t r;
    r = '0;
    r.req = req;
    r.data.bus_address = BASE_ADDRESS | {{(ADDR_W-DSEL_W){1'b0}}, dev_sel};
    r.data.command_byte = cmd;
    return r;
  endfunction

  // Advance the sequencer by one operation and return the result it owes.
  function automatic reading_result_t advance_sequencer(input logic [OP_W-1:0] op,
                                                        input logic [DATA_W-1:0] rd);
    reading_result_t   r;
    logic [DATA_W-1:0] mag;
    int unsigned       steps;
    int unsigned       scaled;
    int unsigned       mul;
    int unsigned       div;
    r = '0;
    case (op)
      OP_START: begin
        r = issue_transfer(REQ_CONVERT, CMD_CONVERT);
        seq_phase = PH_WAIT_ACK;
        conv_ticks = '0;
      end
      OP_TICK: begin
        if (seq_phase == PH_CONVERT) begin
          conv_ticks = conv_ticks + 1'b1;
          if (int'(conv_ticks) >= (int'(TICK_BASE) << res_code)) begin
            r = issue_transfer(REQ_READ, CMD_READ);
            seq_phase = PH_WAIT_READ;
            conv_ticks = '0;
          end
        end
      end
      OP_DONE: begin
        if (seq_phase == PH_WAIT_ACK) begin
          seq_phase = PH_CONVERT;
          conv_ticks = '0;
        end else if (seq_phase == PH_WAIT_READ) begin
          last_reading = rd;
          seq_phase = PH_COMPLETE;
        end
      end
      OP_ERROR: begin
        if (seq_phase == PH_WAIT_ACK || seq_phase == PH_WAIT_READ) begin
          r = issue_transfer(REQ_CONVERT, CMD_CONVERT);
          seq_phase = PH_WAIT_ACK;
          conv_ticks = '0;
        end
      end
      OP_QUERY: begin
        if (seq_phase == PH_COMPLETE) begin
          // negate all 16 bits, so the most negative code reads as 128 degrees
          mag = last_reading[DATA_W-1] ? (16'd0 - last_reading) : last_reading;
          steps = mag >> (7 - res_code);
          case (res_code)
            2'd0:    begin mul = 5;   div = 10;    end
            2'd1:    begin mul = 25;  div = 100;   end
            2'd2:    begin mul = 125; div = 1000;  end
            default: begin mul = 625; div = 10000; end
          endcase
          scaled = steps * mul;
          r.data.is_negative = last_reading[DATA_W-1];
          r.data.whole_degrees = WHOLE_W'(scaled / div);
          r.data.fraction_digits = FRAC_W'(scaled % div);
        end
      end
      default: ;
    endcase
    r.data.measurement_complete = (seq_phase == PH_COMPLETE);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want_v,
                 got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_code = RES_RESET;
      dev_sel = DSEL_RESET;
      seq_phase = PH_IDLE;
      conv_ticks = '0;
      last_reading = '0;
      expected_q.delete();
    end else begin
      // retire the result first: it cannot belong to an item taken at this edge
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: tuser %0d tdata %h", $realtime, out_tuser,
                     out_tdata);
        end else begin
          want = expected_q.pop_front();
          seen = result_data_t'(out_tdata[OUT_TDATA_W-2:0]);
          check_field("bus_request", want.req, out_tuser);
          check_field("bus_address", want.data.bus_address, seen.bus_address);
          check_field("command_byte", want.data.command_byte, seen.command_byte);
          check_field("measurement_complete", want.data.measurement_complete,
                      seen.measurement_complete);
          check_field("is_negative", want.data.is_negative, seen.is_negative);
          check_field("whole_degrees", want.data.whole_degrees, seen.whole_degrees);
          check_field("fraction_digits", want.data.fraction_digits, seen.fraction_digits);
          check_field("tdata pad", 0, out_tdata[OUT_TDATA_W-1]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RESOLUTION: res_code = cfg_data[RES_W-1:0];
          REG_DEVICE_SEL: dev_sel = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(advance_sequencer(in_tuser, in_tdata));
    end
    outstanding = expected_q.size();
  end

endmodule

>>> test/tb.sv
// Stimulus and verdict for the temperature read sequencer, with its checker beside it.
`timescale 1ns / 1ps

module tb;
  import tsrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 550;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int               mismatch_count;
  int               expected_left;
  int               cycles;
  int               useful_items;
  bit               calm;
  logic [RES_W-1:0] cur_res;

  always #5 clk = ~clk;

  temp_sensor_read_sequencer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tsrs_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatch_count),
    .outstanding (expected_left)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Entered and left at a falling edge; valid stays high after the transaction.
  task automatic send_raw(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    // in_tready is registered, so its value now holds at the next rising edge
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    send_raw(op, data);
    useful_items++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_raw(OP_W'($urandom_range(OP_DONE, OP_SPARE_HI)), DATA_W'($urandom));
      send_op(OP_TICK, DATA_W'($urandom));
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_reading();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      4:       return 16'hFFF0;
      5:       return 16'h0010;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Drop valid and hold until every result is back, so registers may change.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [RES_W-1:0] res, input logic [DSEL_W-1:0] dsel);
    write_reg(REG_RESOLUTION, {CFG_DATA_W'($urandom_range(0, 1)) << RES_W} | res);
    write_reg(REG_DEVICE_SEL, dsel);
    cur_res = res;
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      while (!out_tvalid) @(negedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int phase_idx;
    int phase_end;
    cur_res = RES_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle: everything but start is ignored
    send_op(OP_QUERY, 16'hFFFF);
    send_raw(OP_SPARE_HI, 16'h0000);
    send_op(OP_TICK, 16'h0000);
    send_op(OP_DONE, 16'h1234);
    send_op(OP_ERROR, 16'hFFFF);
    settle();
    set_config(2'd0, 3'd7);

    // error during ack wait reissues; done and error are ignored while converting
    send_op(OP_START, 16'h0000);
    send_op(OP_ERROR, 16'h0000);
    send_op(OP_DONE, 16'hFFFF);
    send_op(OP_DONE, 16'hFFFF);
    send_op(OP_ERROR, 16'h0000);
    repeat (int'(TICK_BASE)) send_op(OP_TICK, 16'hFFFF);
    send_op(OP_TICK, 16'h0000);
    send_op(OP_DONE, 16'h8000);
    send_op(OP_QUERY, 16'h0000);
    send_op(OP_TICK, 16'h0000);
    send_op(OP_ERROR, 16'h0000);
    // start from complete leaves the stored reading unreported
    send_op(OP_START, 16'hFFFF);
    send_op(OP_QUERY, 16'hFFFF);

    phase_idx = 0;
    while (useful_items < ITEM_TARGET) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      case (phase_idx % 6)
        0:       set_config(2'd0, 3'd0);
        1:       set_config(2'd3, 3'd7);
        default: set_config(RES_W'($urandom_range(0, 3)), DSEL_W'($urandom_range(0, 7)));
      endcase
      phase_idx++;
      phase_end = useful_items + $urandom_range(30, 70);
      while (useful_items < phase_end && useful_items < ITEM_TARGET) begin
        case ($urandom_range(0, 9))
          6: begin
            // leave a conversion half done, possibly across a resolution change
            send_op(OP_START, DATA_W'($urandom));
            send_op(OP_DONE, DATA_W'($urandom));
            tick_run($urandom_range(1, (int'(TICK_BASE) << cur_res) - 1));
          end
          7: begin
            tick_run($urandom_range(1, 80));
            send_op(OP_DONE, pick_reading());
            send_op(OP_QUERY, DATA_W'($urandom));
          end
          8, 9: begin
            repeat ($urandom_range(1, 5))
              send_raw(OP_W'($urandom_range(OP_START, OP_SPARE_HI)), DATA_W'($urandom));
          end
          default: begin
            send_op(OP_START, DATA_W'($urandom));
            if ($urandom_range(0, 4) == 0)
              send_op(OP_ERROR, DATA_W'($urandom));
            send_op(OP_DONE, DATA_W'($urandom));
            tick_run(int'(TICK_BASE) << cur_res);
            if ($urandom_range(0, 6) == 0) begin
              send_op(OP_ERROR, DATA_W'($urandom));
            end else begin
              send_op(OP_DONE, pick_reading());
              repeat ($urandom_range(1, 3)) send_op(OP_QUERY, DATA_W'($urandom));
            end
          end
        endcase
      end
    end
    settle();
    calm = 1'b0;

    if (mismatch_count == 0 && expected_left == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
